### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/enr_pkg.sv
// ---------------------------------------------------------------------------
// enr_pkg
// Fixed field widths and sequencer state codes for the nth-root block.
// ---------------------------------------------------------------------------
package enr_pkg;

    localparam int EXP_W   = 6;
    localparam int ROOT_W  = 31;
    localparam int S_DATA_W = 40;   // exponent + target, padded to bytes
    localparam int M_DATA_W = 32;   // root, padded to bytes

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_MID  = 3'd1;
    localparam logic [STATE_W-1:0] S_BIT  = 3'd2;
    localparam logic [STATE_W-1:0] S_ACC  = 3'd3;
    localparam logic [STATE_W-1:0] S_SQ   = 3'd4;
    localparam logic [STATE_W-1:0] S_DONE = 3'd5;

endpackage

### rtl/enr_mul.sv
// ---------------------------------------------------------------------------
// enr_mul
// Shared multiplier with a registered product; one operation per cycle while en is high.
// ---------------------------------------------------------------------------
module enr_mul #(
    parameter int W = 31
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] prod
);

    logic [2*W-1:0] prod_reg;

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/exact_integer_nth_root_top.sv
// ---------------------------------------------------------------------------
// exact_integer_nth_root_top
// Exact integer nth root: binary search over candidates with a saturating
// square-and-multiply power on one shared multiplier.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Signals                       Payload (lowest bit up)
// s_*      in   s_tvalid s_tready s_tdata     exponent[5:0], target_value[36:6]
// m_*      out  m_tvalid m_tready m_tdata     root[30:0]
//               m_tuser                       found
//
// Search: at most 31 steps, each computing one candidate's power by
//   square-and-multiply with one multiply in flight at a time; the power
//   stops early once it saturates above the target.
// s_tready is high only while the sequencer is idle.
// A finished result sits in the output register; a stalled m_tready holds
//   the next result in S_DONE until the register frees up.
// Reset (rst_n, async, active low) clears control state only.
//
module exact_integer_nth_root_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [enr_pkg::S_DATA_W-1:0] s_tdata,  // exponent[5:0], target_value[36:6]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [enr_pkg::M_DATA_W-1:0] m_tdata,  // root[30:0], zero pad[31]
    output logic                         m_tuser   // found
);

    import enr_pkg::*;

    `include "assert_macros.svh"

    // effective target width: the field is 31 bits, further cut to VALUE_WIDTH
    localparam int TW = (VALUE_WIDTH < ROOT_W) ? VALUE_WIDTH : ROOT_W;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;      // remaining exponent bits
    logic [TW-1:0]      target_reg, target_next;
    logic [TW:0]        lo_reg, lo_next;        // may reach target+1
    logic [TW-1:0]      hi_reg, hi_next;
    logic [TW-1:0]      mid_reg, mid_next;
    logic [TW-1:0]      base_reg, base_next;
    logic [TW-1:0]      acc_reg, acc_next;
    logic               found_reg, found_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic               m_found_reg, m_found_next;

    logic               mul_en;
    logic [TW-1:0]      mul_a, mul_b;
    logic [2*TW-1:0]    prod;
    logic [TW-1:0]      mid_calc;
    logic               prod_over;
    logic [EXP_W-1:0]   exp_shr;

    enr_mul #(
        .W (TW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // midpoint, valid while lo <= hi
    assign mid_calc  = lo_reg[TW-1:0] + ((hi_reg - lo_reg[TW-1:0]) >> 1);
    // saturation: partial result would exceed the target
    assign prod_over = prod > {{TW{1'b0}}, target_reg};
    assign exp_shr   = exp_reg >> 1;

    always_comb
    begin
        state_next    = state_reg;
        e_next        = e_reg;
        exp_next      = exp_reg;
        target_next   = target_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        root_next     = root_reg;
        m_found_next  = m_found_reg;
        mul_en        = 1'b0;
        mul_a         = base_reg;
        mul_b         = base_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    e_next      = s_tdata[EXP_W-1:0];
                    target_next = s_tdata[EXP_W +: TW];
                    lo_next     = (TW+1)'(1);
                    hi_next     = s_tdata[EXP_W +: TW];
                    found_next  = 1'b0;
                    state_next  = S_MID;
                end
            end
            S_MID:
            begin
                if (lo_reg > {1'b0, hi_reg})
                begin
                    // range exhausted (or empty for a zero target)
                    found_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    base_next  = mid_calc;
                    acc_next   = TW'(1);
                    exp_next   = e_reg;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (exp_reg == '0)
                begin
                    // power complete: acc holds mid^e, never above target
                    if (acc_reg == target_reg)
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (acc_reg < target_reg)
                    begin
                        lo_next    = {1'b0, mid_reg} + (TW+1)'(1);
                        state_next = S_MID;
                    end
                    else
                    begin
                        hi_next    = mid_reg - TW'(1);
                        state_next = S_MID;
                    end
                end
                else if (exp_reg[0])
                begin
                    mul_en     = 1'b1;
                    mul_a      = acc_reg;
                    state_next = S_ACC;
                end
                else
                begin
                    exp_next = exp_shr;
                    if (exp_shr != '0)
                    begin
                        mul_en     = 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            S_ACC:
            begin
                if (prod_over)
                begin
                    hi_next    = mid_reg - TW'(1);
                    state_next = S_MID;
                end
                else
                begin
                    acc_next = prod[TW-1:0];
                    exp_next = exp_shr;
                    if (exp_shr != '0)
                    begin
                        mul_en     = 1'b1;
                        state_next = S_SQ;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_SQ:
            begin
                if (prod_over)
                begin
                    hi_next    = mid_reg - TW'(1);
                    state_next = S_MID;
                end
                else
                begin
                    base_next  = prod[TW-1:0];
                    state_next = S_BIT;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    root_next     = found_reg ? ROOT_W'(mid_reg) : '0;
                    m_found_next  = found_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        exp_reg     <= exp_next;
        target_reg  <= target_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        found_reg   <= found_next;
        root_reg    <= root_next;
        m_found_reg <= m_found_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(root_reg);
    assign m_tuser  = m_found_reg;

    // a reported root is never zero, a miss always reports zero
    `ASSERT_RST(a_found_nonzero, clk, rst_n,
        (m_tvalid && m_tuser) |-> (m_tdata != '0), "found result with zero root")
    `ASSERT_RST(a_miss_zero, clk, rst_n,
        (m_tvalid && !m_tuser) |-> (m_tdata == '0), "miss result with nonzero root")
    // search bounds never cross by more than one
    `ASSERT_RST(a_bounds, clk, rst_n,
        (state_reg == S_MID) |-> (lo_reg <= {1'b0, hi_reg} + (TW+1)'(1)),
        "search bounds crossed")
    // accumulated power stays within the target between multiplies
    `ASSERT_RST(a_acc_bound, clk, rst_n,
        (state_reg == S_BIT) |-> (acc_reg <= target_reg), "power accumulator above target")
    // a pending result is not overwritten
    `ASSERT_ALWAYS(a_no_overwrite, clk,
        (rst_n && m_tvalid && !m_tready && state_reg == S_DONE)
            |=> (state_reg == S_DONE || !rst_n),
        "result overwrite while stalled")

endmodule

### dv/exact_integer_nth_root_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// exact_integer_nth_root_top_test
// Self-checking bench for the exact nth-root block. Every accepted query is
// run through a local binary-search root predictor. The expected answer
// (root, found) is queued in order and compared field by field with each
// result transaction. Directed corner queries come first, then random
// queries in four flow-control phases. The mix favors exact powers and
// their near neighbors.
// ---------------------------------------------------------------------------
module exact_integer_nth_root_top_test;

    import enr_pkg::*;

    localparam int                VALUE_WIDTH = 32;
    localparam longint unsigned   VALUE_MASK  = (64'd1 << VALUE_WIDTH) - 64'd1;
    localparam longint unsigned   TARGET_MAX  = 64'h7FFF_FFFF;
    localparam int                PHASE_ITEMS = 275;
    localparam int                LONG_HOLD   = 3000;
    localparam int                SETTLE_CYC  = 500;

    // one expected answer, with the query kept for reporting
    typedef struct {
        logic [EXP_W-1:0]  exponent;
        logic [ROOT_W-1:0] target;
        logic [ROOT_W-1:0] root;
        logic              found;
    } root_answer_t;

    // -----------------------------------------------------------------------
    // scoreboard: predicts each answer at input acceptance, checks in order
    // -----------------------------------------------------------------------
    class nth_root_scoreboard;
        root_answer_t expected_roots[$];
        int           fail_count;
        int           mismatch_count;

        // base^e, clamped to limit+1 once it would pass limit (base, limit >= 1)
        static function longint unsigned saturated_power(longint unsigned base,
                                                         longint unsigned e,
                                                         longint unsigned limit);
            longint unsigned acc;
            acc = 1;
            while (e > 0) begin
                if (e[0]) begin
                    if (acc > limit / base)
                        return limit + 1;
                    acc = acc * base;
                end
                e = e >> 1;
                if (e > 0) begin
                    if (base > limit / base)
                        return limit + 1;
                    base = base * base;
                end
            end
            return acc;
        endfunction

        // binary search over 1..target, stops at the first exact hit
        function root_answer_t exact_root_of(logic [EXP_W-1:0] e, logic [ROOT_W-1:0] v);
            root_answer_t    ans;
            longint unsigned target, lo, hi, mid, p;
            ans.exponent = e;
            ans.target   = v;
            ans.root     = '0;
            ans.found    = 1'b0;
            target = longint'(v) & VALUE_MASK;
            lo = 1;
            hi = target;
            while (target != 0 && lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                p   = saturated_power(mid, longint'(e), target);
                if (p == target) begin
                    ans.root  = mid[ROOT_W-1:0];
                    ans.found = 1'b1;
                    break;
                end
                else if (p < target)
                    lo = mid + 1;
                else
                    hi = mid - 1;   // mid is never zero here
            end
            return ans;
        endfunction

        function void note_input(logic [EXP_W-1:0] e, logic [ROOT_W-1:0] v);
            expected_roots.push_back(exact_root_of(e, v));
        endfunction

        function void check_result(logic [ROOT_W-1:0] root, logic found);
            root_answer_t want;
            if (expected_roots.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: root %0d found %0b",
                             root, found);
                return;
            end
            want = expected_roots.pop_front();
            if (root !== want.root || found !== want.found) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch e=%0d v=%0d: root exp %0d got %0d, found exp %0b got %0b",
                             want.exponent, want.target, want.root, root, want.found, found);
            end
        endfunction

        function int outstanding();
            return expected_roots.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset, DUT
    // -----------------------------------------------------------------------
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // exponent[5:0], target_value[36:6], pad
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // root[30:0], pad[31]
    logic                m_tuser;           // found

    nth_root_scoreboard sb = new();

    // flow-control knobs: idle and stall in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;     // long receiver hold-off, in cycles

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    exact_integer_nth_root_top #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // -----------------------------------------------------------------------
    // monitor: both channels sampled at the edge that completes a transaction.
    // Results are checked before the new query is noted; a query is never
    // answered at the edge that accepts it, so the two never refer to the same query.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[ROOT_W-1:0], m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[EXP_W-1:0], s_tdata[EXP_W +: ROOT_W]);
        end
    end

    // -----------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off counted here on request
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // sender: offer one query, hold until taken, then maybe go idle a while
    // -----------------------------------------------------------------------
    task automatic send_root_query(input logic [EXP_W-1:0] e, input logic [ROOT_W-1:0] v);
        s_tdata  <= S_DATA_W'({v, e});
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_all_answered();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // random query: exact powers, their neighbors, wide random, low exponents, tiny targets
    task automatic pick_root_query(output logic [EXP_W-1:0] e, output logic [ROOT_W-1:0] v);
        int              kind;
        int              bits;
        longint unsigned r, p;
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            if ($urandom_range(9) == 0)
                e = EXP_W'($urandom_range(32, 63));
            else
                e = EXP_W'($urandom_range(1, 31));
            bits = 31 / int'(e) + 1;
            if (bits > 31)
                bits = 31;
            r = $urandom_range(1, 32'd1 << bits);
            while (nth_root_scoreboard::saturated_power(r, longint'(e), TARGET_MAX) > TARGET_MAX)
                r = r >> 1;
            p = nth_root_scoreboard::saturated_power(r, longint'(e), TARGET_MAX);
            // neighbors of an exact power, which miss unless the exponent is one
            if (kind < 12)
            begin
                if ($urandom_range(1) == 1 && p < TARGET_MAX)
                    p = p + 1;
                else
                    p = p - 1;
            end
            v = p[ROOT_W-1:0];
        end
        else if (kind < 80)
        begin
            e = EXP_W'($urandom_range(63));
            v = ROOT_W'($urandom());
        end
        else if (kind < 90)
        begin
            e = EXP_W'($urandom_range(3));
            v = ROOT_W'($urandom());
        end
        else
        begin
            e = EXP_W'($urandom_range(63));
            v = ROOT_W'($urandom_range(20));
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [EXP_W-1:0]  dir_exp[$];
        logic [ROOT_W-1:0] dir_val[$];
        logic [EXP_W-1:0]  e;
        logic [ROOT_W-1:0] v;
        int                phase_idle[4];
        int                phase_stall[4];

        // zero targets, exponent zero, exponent one, largest values, exact
        // squares/cubes near the top, high exponents, and near misses
        dir_exp = '{6'd0, 6'd5, 6'd63, 6'd0, 6'd0, 6'd63, 6'd62, 6'd63, 6'd1, 6'd1,
                    6'd1, 6'd2, 6'd2, 6'd2, 6'd3, 6'd3, 6'd30, 6'd19, 6'd5, 6'd10,
                    6'd2, 6'd31, 6'd0};
        dir_val = '{31'd0, 31'd0, 31'd0, 31'd1, 31'd2, 31'd1, 31'd1, 31'h7FFF_FFFF,
                    31'h7FFF_FFFF, 31'd1, 31'd12345, 31'd2147395600, 31'd2147395601,
                    31'h7FFF_FFFF, 31'd2146689000, 31'd1000001, 31'd1073741824,
                    31'd1162261467, 31'd243, 31'd1024, 31'd4, 31'h4000_0000,
                    31'h7FFF_FFFF};
        phase_idle  = '{0, 72, 0, 19};
        phase_stall = '{0, 0, 72, 19};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_exp[i])
            send_root_query(dir_exp[i], dir_val[i]);
        s_tvalid <= 1'b0;
        wait_all_answered();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long output hold-off while queries keep coming: output
                // register and done state fill, then s_tready must drop
                if (ph == 0 && i == 60)
                    hold_request = LONG_HOLD;
                pick_root_query(e, v);
                send_root_query(e, v);
            end
            // sender pauses until every answer is back
            s_tvalid <= 1'b0;
            wait_all_answered();
        end

        repeat (SETTLE_CYC) @(posedge clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
